### hdl/snetd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package snetd_pkg;

  // Sizes of the network and of the fixed-point words
  localparam int MAX_NEURONS    = 32;
  localparam int SIG_TABLE_SIZE = 256;
  localparam int SIG_TBL_LOG2   = $clog2(SIG_TABLE_SIZE);
  localparam int NEURON_AW      = $clog2(MAX_NEURONS);
  localparam int CNT_W          = 6;
  localparam int IDX_W          = 5;
  localparam int WGT_W          = 16;
  localparam int RES_W          = 32;
  localparam int PT_W           = 17;
  localparam int ACC_W          = 56;
  localparam int ONE_Q16        = 65536;

  // Item codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // One stored neuron: bias in the low half-word, y weight on top
  typedef struct packed {
    logic [WGT_W-1:0] y_w;
    logic [WGT_W-1:0] x_w;
    logic [WGT_W-1:0] out_w;
    logic [WGT_W-1:0] bias;
  } nrn_wgt_t;

  typedef logic [SIG_TABLE_SIZE:0][PT_W-1:0] sig_tbl_t;

  // Unsigned quotient by restoring long division, evaluated at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, dvs}) begin
        rem  = rem - {1'b0, dvs};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid at point k of the table, Q0.16, evaluated at elaboration
  function automatic logic [PT_W-1:0] sig_point(input int k);
    logic [63:0] n;
    logic [63:0] twok;
    logic [63:0] a;
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] d;
    logic [63:0] den;
    logic [63:0] pos;
    n    = 64'(SIG_TABLE_SIZE);
    twok = 64'(2 * k);
    a    = (twok >= n) ? twok - n : n - twok;
    u    = (a << 30) >> (SIG_TBL_LOG2 + 1);
    term = 64'd1 << 30;
    sum  = term;
    for (int i = 1; i <= 14; i++) begin
      term = udiv64((term * u) >> 30, 64'(i));
      sum  = sum + term;
    end
    d = udiv64(64'd1 << 60, sum);
    for (int i = 0; i < 4; i++) begin
      d = (d * d + (64'd1 << 29)) >> 30;
    end
    den = (64'd1 << 30) + d;
    pos = udiv64((64'd1 << 46) + (den >> 1), den);
    if (twok < n) begin
      pos = 64'(ONE_Q16) - pos;
    end
    return PT_W'(pos);
  endfunction

  function automatic sig_tbl_t build_sig_tbl();
    sig_tbl_t tbl;
    for (int k = 0; k <= SIG_TABLE_SIZE; k++) begin
      tbl[k] = sig_point(k);
    end
    return tbl;
  endfunction

  localparam sig_tbl_t SIG_TBL = build_sig_tbl();

endpackage

`default_nettype wire

### hdl/sigmoid_net_eval_with_derivatives.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// config    cfg_we                 cfg_wdata (active_neurons)
// input     in_valid / in_stall    func, neuron_index, weights, x_coord, y_coord
// output    out_valid / out_stall  n_value, n_dx, n_dxx, n_dy, n_dyy, n_dxy, saturated
//
// A load item is written to the weight RAM as it is accepted. An evaluate item
// runs 18 steps for each of N neurons, N being the clipped neuron count (a weight
// fetch from the RAM, a table lookup and 16 products on the one shared multiplier),
// then hands its result to the output register. Reset (rst, synchronous) clears
// the sequencer, the output valid and sets active_neurons to 32; the weights are
// not cleared. The input is stalled while an evaluation runs and while its result
// waits for a full output register; a result in the output register waits there
// while the next item is accepted.

module sigmoid_net_eval_with_derivatives (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [snetd_pkg::CNT_W-1:0]       cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              func,
  input  wire logic [snetd_pkg::IDX_W-1:0]       neuron_index,
  input  wire logic signed [snetd_pkg::WGT_W-1:0] bias_weight,
  input  wire logic signed [snetd_pkg::WGT_W-1:0] output_weight,
  input  wire logic signed [snetd_pkg::WGT_W-1:0] x_weight,
  input  wire logic signed [snetd_pkg::WGT_W-1:0] y_weight,
  input  wire logic signed [snetd_pkg::WGT_W-1:0] x_coord,
  input  wire logic signed [snetd_pkg::WGT_W-1:0] y_coord,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [snetd_pkg::RES_W-1:0]     n_value,
  output logic signed [snetd_pkg::RES_W-1:0]     n_dx,
  output logic signed [snetd_pkg::RES_W-1:0]     n_dxx,
  output logic signed [snetd_pkg::RES_W-1:0]     n_dy,
  output logic signed [snetd_pkg::RES_W-1:0]     n_dyy,
  output logic signed [snetd_pkg::RES_W-1:0]     n_dxy,
  output logic                                   saturated
);
  import snetd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [4:0] STP_FETCH = 5'd0;
  localparam logic [4:0] STP_ZX    = 5'd1;
  localparam logic [4:0] STP_ZY    = 5'd2;
  localparam logic [4:0] STP_LUT   = 5'd3;
  localparam logic [4:0] STP_INTP  = 5'd4;
  localparam logic [4:0] STP_S1    = 5'd5;
  localparam logic [4:0] STP_S2    = 5'd6;
  localparam logic [4:0] STP_A0    = 5'd7;
  localparam logic [4:0] STP_VX    = 5'd8;
  localparam logic [4:0] STP_VY    = 5'd9;
  localparam logic [4:0] STP_DX    = 5'd10;
  localparam logic [4:0] STP_DY    = 5'd11;
  localparam logic [4:0] STP_TXX   = 5'd12;
  localparam logic [4:0] STP_AXX   = 5'd13;
  localparam logic [4:0] STP_TYY   = 5'd14;
  localparam logic [4:0] STP_AYY   = 5'd15;
  localparam logic [4:0] STP_TXY   = 5'd16;
  localparam logic [4:0] STP_AXY   = 5'd17;

  localparam logic signed [33:0] Z_OFF  = 34'sd134217728;
  localparam logic signed [33:0] Z_SPAN = 34'sd268435456;
  localparam int MUL_AW = 36;
  localparam int MUL_BW = 26;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  logic [1:0]              state;
  logic [4:0]              step;
  logic [CNT_W-1:0]        active_neurons;
  logic [CNT_W-1:0]        nrn;
  logic [CNT_W-1:0]        num;
  logic                    in_acc;
  logic                    out_load;
  logic [CNT_W-1:0]        eval_cnt;
  nrn_wgt_t                wgt;
  nrn_wgt_t                wgt_in;
  logic signed [WGT_W-1:0] b_w;
  logic signed [WGT_W-1:0] v_w;
  logic signed [WGT_W-1:0] wx_w;
  logic signed [WGT_W-1:0] wy_w;
  logic signed [WGT_W-1:0] x_q;
  logic signed [WGT_W-1:0] y_q;
  logic signed [33:0]      z;
  logic signed [33:0]      zz;
  logic [PT_W-1:0]         t_a;
  logic signed [17:0]      dba;
  logic [23:0]             frac;
  logic [PT_W-1:0]         lut_a;
  logic signed [17:0]      lut_d;
  logic [23:0]             lut_f;
  logic [SIG_TBL_LOG2+23:0] pos;
  logic [SIG_TBL_LOG2-1:0] lut_idx;
  logic [SIG_TBL_LOG2:0]   lut_nxt;
  logic [PT_W-1:0]         s0;
  logic [14:0]             s1;
  logic signed [15:0]      s2;
  logic [17:0]             one_m_s0;
  logic signed [17:0]      one_m_2s0;
  logic signed [31:0]      vx;
  logic signed [31:0]      vy;
  logic signed [34:0]      t;
  logic signed [ACC_W-1:0] acc0;
  logic signed [ACC_W-1:0] accdx;
  logic signed [ACC_W-1:0] accdy;
  logic signed [ACC_W-1:0] accxx;
  logic signed [ACC_W-1:0] accyy;
  logic signed [ACC_W-1:0] accxy;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;
  logic signed [MUL_PW-1:0] ip_sh;
  logic [RES_W:0]          f0;
  logic [RES_W:0]          fdx;
  logic [RES_W:0]          fdxx;
  logic [RES_W:0]          fdy;
  logic [RES_W:0]          fdyy;
  logic [RES_W:0]          fdxy;

  // Round a Q.40 sum to Q16.16 and clip; the top bit flags a clip
  function automatic logic [RES_W:0] fin_word(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] r;
    logic signed [ACC_W:0] rmax;
    logic signed [ACC_W:0] rmin;
    rmax = (ACC_W+1)'(64'sh7FFF_FFFF);
    rmin = -rmax - (ACC_W+1)'(1);
    r = ((ACC_W+1)'(acc) + (ACC_W+1)'(64'sh80_0000)) >>> 24;
    if (r > rmax) begin
      return {1'b1, RES_W'(rmax)};
    end else if (r < rmin) begin
      return {1'b1, RES_W'(rmin)};
    end
    return {1'b0, RES_W'(r)};
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == ST_FIN) && (!out_valid || !out_stall);
  assign eval_cnt = (32'(active_neurons) > MAX_NEURONS) ? CNT_W'(MAX_NEURONS)
                                                        : active_neurons;

  // Weight store
  assign wgt_in = '{y_w: y_weight, x_w: x_weight, out_w: output_weight, bias: bias_weight};

  snetd_ram #(
    .WIDTH($bits(nrn_wgt_t)),
    .DEPTH(MAX_NEURONS)
  ) u_wgt_ram (
    .clk  (clk),
    .we   (in_acc && (func == FUNC_LOAD) && (32'(neuron_index) < MAX_NEURONS)),
    .waddr(NEURON_AW'(neuron_index)),
    .wdata(wgt_in),
    .raddr(nrn[NEURON_AW-1:0]),
    .rdata(wgt)
  );

  assign b_w  = wgt.bias;
  assign v_w  = wgt.out_w;
  assign wx_w = wgt.x_w;
  assign wy_w = wgt.y_w;

  // Table lookup: clamp outside [-8,8), else split position into index and fraction
  always_comb begin
    zz      = z + Z_OFF;
    pos     = (SIG_TBL_LOG2+24)'(zz[27:0]) << (SIG_TBL_LOG2 - 4);
    lut_idx = pos[24 +: SIG_TBL_LOG2];
    lut_nxt = {1'b0, lut_idx} + (SIG_TBL_LOG2+1)'(1);
    lut_f   = pos[23:0];
    lut_a   = SIG_TBL[lut_idx];
    lut_d   = $signed({1'b0, SIG_TBL[lut_nxt]}) - $signed({1'b0, lut_a});
    if (zz < 0) begin
      lut_a = SIG_TBL[0];
      lut_d = '0;
    end else if (zz >= Z_SPAN) begin
      lut_a = SIG_TBL[SIG_TABLE_SIZE];
      lut_d = '0;
    end
  end

  assign one_m_s0  = 18'(ONE_Q16) - {1'b0, s0};
  assign one_m_2s0 = $signed(18'(ONE_Q16) - {s0, 1'b0});

  // Select the operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      STP_ZX:   begin mul_a = MUL_AW'(wx_w);         mul_b = MUL_BW'(x_q);       end
      STP_ZY:   begin mul_a = MUL_AW'(wy_w);         mul_b = MUL_BW'(y_q);       end
      STP_INTP: begin mul_a = MUL_AW'(dba);          mul_b = MUL_BW'(frac);      end
      STP_S1:   begin mul_a = MUL_AW'(s0);           mul_b = MUL_BW'(one_m_s0);  end
      STP_S2:   begin mul_a = MUL_AW'(s1);           mul_b = MUL_BW'(one_m_2s0); end
      STP_A0:   begin mul_a = MUL_AW'(v_w);          mul_b = MUL_BW'(s0);        end
      STP_VX:   begin mul_a = MUL_AW'(v_w);          mul_b = MUL_BW'(wx_w);      end
      STP_VY:   begin mul_a = MUL_AW'(v_w);          mul_b = MUL_BW'(wy_w);      end
      STP_DX:   begin mul_a = MUL_AW'(vx);           mul_b = MUL_BW'(s1);        end
      STP_DY:   begin mul_a = MUL_AW'(vy);           mul_b = MUL_BW'(s1);        end
      STP_TXX:  begin mul_a = MUL_AW'(vx);           mul_b = MUL_BW'(wx_w);      end
      STP_TYY:  begin mul_a = MUL_AW'(vy);           mul_b = MUL_BW'(wy_w);      end
      STP_TXY:  begin mul_a = MUL_AW'(vx);           mul_b = MUL_BW'(wy_w);      end
      STP_AXX,
      STP_AYY,
      STP_AXY:  begin mul_a = MUL_AW'(t);            mul_b = MUL_BW'(s2);        end
      default:  begin mul_a = '0;                    mul_b = '0;                 end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign ip_sh = (mul_p + MUL_PW'(64'sh80_0000)) >>> 24;

  // Sequencer: accept items, step through each neuron, hand over the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      step           <= STP_FETCH;
      active_neurons <= CNT_W'(32);
    end else begin
      if (cfg_we) begin
        active_neurons <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (func == FUNC_EVAL)) begin
            step  <= STP_FETCH;
            state <= (eval_cnt == '0) ? ST_FIN : ST_RUN;
          end
        end
        ST_RUN: begin
          if (step == STP_AXY) begin
            step <= STP_FETCH;
            if (nrn + CNT_W'(1) == num) begin
              state <= ST_FIN;
            end
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && (func == FUNC_EVAL)) begin
      x_q   <= x_coord;
      y_q   <= y_coord;
      nrn   <= '0;
      num   <= eval_cnt;
      acc0  <= '0;
      accdx <= '0;
      accdy <= '0;
      accxx <= '0;
      accyy <= '0;
      accxy <= '0;
    end else if (state == ST_RUN) begin
      unique case (step)
        STP_ZX:   z     <= (34'(b_w) <<< 12) + 34'(mul_p);
        STP_ZY:   z     <= z + 34'(mul_p);
        STP_LUT: begin
          t_a  <= lut_a;
          dba  <= lut_d;
          frac <= lut_f;
        end
        STP_INTP: s0    <= t_a + PT_W'(ip_sh);
        STP_S1:   s1    <= 15'((mul_p + MUL_PW'(32768)) >>> 16);
        STP_S2:   s2    <= 16'((mul_p + MUL_PW'(32768)) >>> 16);
        STP_A0:   acc0  <= acc0 + (ACC_W'(mul_p) <<< 12);
        STP_VX:   vx    <= 32'(mul_p);
        STP_VY:   vy    <= 32'(mul_p);
        STP_DX:   accdx <= accdx + ACC_W'(mul_p);
        STP_DY:   accdy <= accdy + ACC_W'(mul_p);
        STP_TXX,
        STP_TYY,
        STP_TXY:  t     <= 35'((mul_p + MUL_PW'(2048)) >>> 12);
        STP_AXX:  accxx <= accxx + ACC_W'(mul_p);
        STP_AYY:  accyy <= accyy + ACC_W'(mul_p);
        STP_AXY: begin
          accxy <= accxy + ACC_W'(mul_p);
          nrn   <= nrn + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Round and clip the six sums
  assign f0   = fin_word(acc0);
  assign fdx  = fin_word(accdx);
  assign fdxx = fin_word(accxx);
  assign fdy  = fin_word(accdy);
  assign fdyy = fin_word(accyy);
  assign fdxy = fin_word(accxy);

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      n_value   <= f0[RES_W-1:0];
      n_dx      <= fdx[RES_W-1:0];
      n_dxx     <= fdxx[RES_W-1:0];
      n_dy      <= fdy[RES_W-1:0];
      n_dyy     <= fdyy[RES_W-1:0];
      n_dxy     <= fdxy[RES_W-1:0];
      saturated <= f0[RES_W] | fdx[RES_W] | fdxx[RES_W] | fdy[RES_W] | fdyy[RES_W]
                   | fdxy[RES_W];
    end
  end

endmodule

`default_nettype wire

### hdl/snetd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module snetd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write one word, read one word with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

import snetd_pkg::*;

typedef struct {
  logic signed [31:0] deriv [6];
  logic               sat;
} net_result_t;

class snet_scoreboard;
  longint unsigned sig_pts [257];
  logic [63:0]     weights [32];
  int unsigned     neuron_cnt;
  net_result_t     pending [$];
  int              errors;
  string           names [6] = '{"n_value", "n_dx", "n_dxx", "n_dy", "n_dyy", "n_dxy"};

  function new();
    longint unsigned a, u, term, sum, d, den, pos;
    for (int k = 0; k <= 256; k++) begin
      a    = (2 * k >= 256) ? 2 * k - 256 : 256 - 2 * k;
      u    = (a << 30) / 512;
      term = 64'd1 << 30;
      sum  = term;
      for (int i = 1; i <= 14; i++) begin
        term = ((term * u) >> 30) / i;
        sum  = sum + term;
      end
      d = (64'd1 << 60) / sum;
      repeat (4) d = (d * d + (64'd1 << 29)) >> 30;
      den = (64'd1 << 30) + d;
      pos = ((64'd1 << 46) + den / 2) / den;
      sig_pts[k] = (2 * k >= 256) ? pos : 65536 - pos;
    end
    neuron_cnt = 32;
    errors = 0;
  endfunction

  function void set_count(int unsigned c);
    neuron_cnt = c;
  endfunction

  // Interpolated sigmoid of z in Q.24, Q0.16 out
  function longint sigmoid(longint z);
    longint zz;
    longint unsigned p, idx, frac;
    zz = z + (64'sd8 <<< 24);
    if (zz < 0) return sig_pts[0];
    if (zz >= (64'sd16 <<< 24)) return sig_pts[256];
    p    = zz << 4;
    idx  = p >> 24;
    frac = p & 64'hFF_FFFF;
    return (sig_pts[idx] * ((64'd1 << 24) - frac) + sig_pts[idx + 1] * frac
            + (64'd1 << 23)) >> 24;
  endfunction

  // Round Q.40 to Q16.16, clip to 32 bits
  function logic signed [31:0] to_q16(longint acc, inout logic sat);
    longint r;
    r = (acc + (64'sd1 <<< 23)) >>> 24;
    if (r > 64'sd2147483647) begin r = 64'sd2147483647; sat = 1'b1; end
    if (r < -64'sd2147483648) begin r = -64'sd2147483648; sat = 1'b1; end
    return r[31:0];
  endfunction

  // Store a load, or sum the active neurons for an evaluate
  function void note_item(logic fn, logic [4:0] idx, logic [15:0] b, logic [15:0] v,
                          logic [15:0] wx, logic [15:0] wy, logic [15:0] xc,
                          logic [15:0] yc);
    longint x, y, nb, nv, nwx, nwy, z, s0, s1, s2, vx, vy;
    longint acc [6];
    net_result_t res;
    int unsigned n;
    if (fn == FUNC_LOAD) begin
      weights[idx] = {wy, wx, v, b};
      return;
    end
    x = $signed(xc);
    y = $signed(yc);
    foreach (acc[j]) acc[j] = 0;
    n = (neuron_cnt > 32) ? 32 : neuron_cnt;
    for (int i = 0; i < n; i++) begin
      nb  = $signed(weights[i][15:0]);
      nv  = $signed(weights[i][31:16]);
      nwx = $signed(weights[i][47:32]);
      nwy = $signed(weights[i][63:48]);
      z   = nb * 4096 + nwx * x + nwy * y;
      s0  = sigmoid(z);
      s1  = (s0 * (65536 - s0) + 32768) >>> 16;
      s2  = (s1 * (65536 - 2 * s0) + 32768) >>> 16;
      vx  = nv * nwx;
      vy  = nv * nwy;
      acc[0] += nv * s0 * 4096;
      acc[1] += vx * s1;
      acc[2] += ((vx * nwx + 2048) >>> 12) * s2;
      acc[3] += vy * s1;
      acc[4] += ((vy * nwy + 2048) >>> 12) * s2;
      acc[5] += ((vx * nwy + 2048) >>> 12) * s2;
    end
    res.sat = 1'b0;
    foreach (acc[j]) res.deriv[j] = to_q16(acc[j], res.sat);
    pending.push_back(res);
  endfunction

  task report(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Compare one result with the oldest expectation
  task check_result(net_result_t got);
    net_result_t exp_r;
    if (pending.size() == 0) begin
      report("result with none expected");
      return;
    end
    exp_r = pending.pop_front();
    foreach (got.deriv[j])
      if (got.deriv[j] !== exp_r.deriv[j])
        report($sformatf("%s got %0d want %0d", names[j], got.deriv[j], exp_r.deriv[j]));
    if (got.sat !== exp_r.sat)
      report($sformatf("saturated got %0b want %0b", got.sat, exp_r.sat));
  endtask
endclass

module tb;
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [5:0]        cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              func = FUNC_LOAD;
  logic [4:0]        neuron_index = '0;
  logic signed [15:0] bias_weight = '0, output_weight = '0, x_weight = '0, y_weight = '0;
  logic signed [15:0] x_coord = '0, y_coord = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [31:0] n_value, n_dx, n_dxx, n_dy, n_dyy, n_dxy;
  logic              saturated;

  snet_scoreboard net_model = new();
  int stall_left = 0;

  sigmoid_net_eval_with_derivatives uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .neuron_index(neuron_index), .bias_weight(bias_weight),
    .output_weight(output_weight), .x_weight(x_weight), .y_weight(y_weight),
    .x_coord(x_coord), .y_coord(y_coord), .out_valid(out_valid),
    .out_stall(out_stall), .n_value(n_value), .n_dx(n_dx), .n_dxx(n_dxx),
    .n_dy(n_dy), .n_dyy(n_dyy), .n_dxy(n_dxy), .saturated(saturated)
  );

  always #10 clk = ~clk;

  // Mostly short pauses, now and then a long one
  function automatic int pick_gap();
    int r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Field value with extra weight on the extremes
  function automatic logic [15:0] pick_word();
    int r = $urandom_range(19);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r < 8) return 16'($signed($urandom_range(0, 4095)) - 2048);
    return 16'($urandom);
  endfunction

  // Toggle the receiver stall in runs
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= (pick_gap() == 0) ? $urandom_range(1, 30) : pick_gap();
      out_stall  <= ($urandom_range(3) == 0);
    end
  end

  // Note accepted inputs and config writes
  always @(posedge clk) begin
    if (!rst && cfg_we) net_model.set_count(cfg_wdata);
    if (!rst && in_valid && !in_stall)
      net_model.note_item(func, neuron_index, bias_weight, output_weight, x_weight,
                          y_weight, x_coord, y_coord);
  end

  // Check accepted results
  always @(posedge clk) begin
    net_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.deriv = '{n_value, n_dx, n_dxx, n_dy, n_dyy, n_dxy};
      got.sat   = saturated;
      net_model.check_result(got);
    end
  end

  task automatic send_item(logic fn, logic [4:0] idx, logic [15:0] b, logic [15:0] v,
                           logic [15:0] wx, logic [15:0] wy, logic [15:0] xc,
                           logic [15:0] yc);
    int gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= fn;
    neuron_index  <= idx;
    bias_weight   <= b;
    output_weight <= v;
    x_weight      <= wx;
    y_weight      <= wy;
    x_coord       <= xc;
    y_coord       <= yc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_neuron(logic [4:0] idx, logic [15:0] b, logic [15:0] v,
                             logic [15:0] wx, logic [15:0] wy);
    send_item(FUNC_LOAD, idx, b, v, wx, wy, pick_word(), pick_word());
  endtask

  task automatic evaluate(logic [15:0] xc, logic [15:0] yc);
    send_item(FUNC_EVAL, 5'($urandom), pick_word(), pick_word(), pick_word(),
              pick_word(), xc, yc);
  endtask

  // Drain all results, then write the neuron count
  task automatic set_neuron_count(logic [5:0] c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (net_model.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [5:0] counts [5] = '{6'd32, 6'd63, 6'd1, 6'd7, 6'd0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme and milder weights for two neurons, centre and corner points, count 0
    set_neuron_count(6'd2);
    load_neuron(5'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    load_neuron(5'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    evaluate(16'h0000, 16'h0000);
    evaluate(16'h7FFF, 16'h7FFF);
    evaluate(16'h8000, 16'h8000);
    evaluate(16'h7FFF, 16'h8000);
    load_neuron(5'd0, 16'h0000, 16'h1000, 16'h0000, 16'h0000);
    load_neuron(5'd1, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF);
    evaluate(16'h0000, 16'h0000);
    evaluate(16'h1234, 16'hEDCC);
    set_neuron_count(6'd0);
    evaluate(16'h7FFF, 16'h8000);

    // Fill every neuron before any wider sum
    for (int i = 0; i < 32; i++)
      load_neuron(5'(i), pick_word(), pick_word(), pick_word(), pick_word());

    // Random phases, one per neuron count
    for (int ph = 0; ph < 6; ph++) begin
      set_neuron_count(ph < 5 ? counts[ph] : 6'($urandom));
      repeat (165) begin
        if ($urandom_range(99) < 55)
          load_neuron(5'($urandom), pick_word(), pick_word(), pick_word(), pick_word());
        else
          evaluate(pick_word(), pick_word());
      end
    end

    // Drain and finish
    in_valid <= 1'b0;
    @(posedge clk);
    while (net_model.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (net_model.errors == 0) begin
      $display("sigmoid_net_eval_with_derivatives: match");
    end else begin
      $display("sigmoid_net_eval_with_derivatives: mismatch");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #80ms;
    $display("sigmoid_net_eval_with_derivatives: mismatch");
    $finish;
  end
endmodule
